@@ design/tlth_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlth_pkg: shared types and constants for the ticket lock table
// Table geometry, command codes, entry layout and controller interface.
// ----------------------------------------------------------------------------
package tlth_pkg;

  localparam int NODE_COUNT  = 8;
  localparam int LOCK_COUNT  = 1024;
  localparam int ENTRY_COUNT = NODE_COUNT * LOCK_COUNT;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam int TICKET_W    = 32;
  localparam int COUNT_W     = 16;
  localparam int MAXHO_W     = 8;
  localparam int NODE_W      = 3;
  localparam int INDEX_W     = 10;
  localparam int CMD_W       = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [MAXHO_W-1:0] MAXHO_RESET = 8'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic [TICKET_W-1:0] next_ticket;
    logic [TICKET_W-1:0] now_serving;
    logic                hand_flag;
    logic [COUNT_W-1:0]  hand_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

@@ design/tlth_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlth_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tlth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tlth_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlth_ctrl: sequencer for the ticket lock table
// Clearing sweep after reset, then accept / execute per item.
// ----------------------------------------------------------------------------
module tlth_ctrl import tlth_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.clear_en = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    busy         = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ design/tlth_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlth_dp: datapath of the ticket lock table
// Entry RAM, item registers, read-modify-write logic and result registers.
// ----------------------------------------------------------------------------
module tlth_dp import tlth_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node_id,
  input  logic [INDEX_W-1:0]  lock_slot,
  input  logic [TICKET_W-1:0] ticket,
  input  logic                cfg_wr_en,
  input  logic [MAXHO_W-1:0]  cfg_wr_data,
  output logic                done,
  output logic [TICKET_W-1:0] issued_ticket,
  output logic                granted,
  output logic                handoff
);

  logic [MAXHO_W-1:0]  max_hand_over;
  logic [ADDR_W-1:0]   clr_cnt;

  cmd_t                cmd_q;
  logic [TICKET_W-1:0] tk_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                ok_q;

  logic [ADDR_W-1:0]   in_addr;
  logic                in_ok;

  entry_t              rd_entry;
  entry_t              new_entry;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;

  logic [TICKET_W-1:0] res_ticket;
  logic                res_grant;
  logic                res_hand;
  logic [TICKET_W-1:0] pending;
  logic                give;
  logic [COUNT_W-1:0]  count_inc;

  // entry index = node * LOCK_COUNT + index
  assign in_addr = ADDR_W'(32'(node_id) * LOCK_COUNT + 32'(lock_slot));
  assign in_ok   = (32'(node_id) < NODE_COUNT) && (32'(lock_slot) < LOCK_COUNT)
                   && (cmd_t'(command) != CMD_NONE);

  assign status.clear_last = (clr_cnt == ADDR_W'(ENTRY_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_hand_over <= MAXHO_RESET;
    end else if (cfg_wr_en) begin
      max_hand_over <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= cmd_t'(command);
      tk_q   <= ticket;
      addr_q <= in_addr;
      ok_q   <= in_ok;
    end
  end

  // read address follows the ports; data lands in the execute cycle
  tlth_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (rd_entry)
  );

  assign count_inc = (rd_entry.hand_count != COUNT_MAX) ?
                     rd_entry.hand_count + 1'b1 : rd_entry.hand_count;
  assign pending   = rd_entry.next_ticket - rd_entry.now_serving;
  assign give      = (pending > TICKET_W'(1)) &&
                     (rd_entry.hand_count < COUNT_W'(max_hand_over));

  always_comb begin
    new_entry  = rd_entry;
    res_ticket = '0;
    res_grant  = 1'b0;
    res_hand   = 1'b0;
    case (cmd_q)
      CMD_ACQUIRE: begin
        res_ticket            = rd_entry.next_ticket;
        new_entry.next_ticket = rd_entry.next_ticket + 1'b1;
        if (rd_entry.next_ticket == rd_entry.now_serving) begin
          res_grant            = 1'b1;
          res_hand             = rd_entry.hand_flag;
          new_entry.hand_count = count_inc;
        end
      end
      CMD_POLL: begin
        res_ticket = tk_q;
        if (tk_q == rd_entry.now_serving) begin
          res_grant            = 1'b1;
          res_hand             = rd_entry.hand_flag;
          new_entry.hand_count = count_inc;
        end
      end
      CMD_RELEASE: begin
        res_hand            = give;
        new_entry.hand_flag = give;
        if (!give) begin
          new_entry.hand_count = '0;
        end
        if (pending != '0) begin
          new_entry.now_serving = rd_entry.now_serving + 1'b1;
        end
      end
      default: begin
        new_entry = rd_entry;
      end
    endcase
    if (!ok_q) begin
      res_ticket = '0;
      res_grant  = 1'b0;
      res_hand   = 1'b0;
    end
  end

  assign ram_we    = cmd.clear_en || (cmd.exec && ok_q);
  assign ram_waddr = cmd.clear_en ? clr_cnt : addr_q;
  assign ram_wdata = cmd.clear_en ? entry_t'('0) : new_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      issued_ticket <= res_ticket;
      granted       <= res_grant;
      handoff       <= res_hand;
    end
  end

endmodule

@@ design/ticket_lock_table_hand_over_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_lock_table_hand_over_core: table of local ticket locks with hand-over
// One entry per node and lock index; acquire, poll and release commands.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the whole entry table to zero, one
// entry per cycle; busy stays high for that time. Then an item is taken
// when start is high and busy low. The accept cycle starts the RAM read of
// the addressed entry, the next cycle does the read-modify-write and busy
// is high during it. The result appears in the cycle after that on
// issued_ticket, granted and handoff, marked by a single-cycle done strobe;
// it is not held, so the receiver must take it in that cycle. A new item
// can be accepted in the same cycle that done is high. max_hand_over is
// written through cfg_wr_en / cfg_wr_data at any time, including during
// the clearing sweep; it should only change while no item is in flight.
// ----------------------------------------------------------------------------
module ticket_lock_table_hand_over_core import tlth_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // item request
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node_id,
  input  logic [INDEX_W-1:0]  lock_slot,
  input  logic [TICKET_W-1:0] ticket,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [MAXHO_W-1:0]  cfg_wr_data,
  // result
  output logic                done,
  output logic [TICKET_W-1:0] issued_ticket,
  output logic                granted,
  output logic                handoff
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // sequencer: clear sweep, then idle / execute
  tlth_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (ctrl_cmd),
    .busy   (busy)
  );

  // entry table and per-command update logic
  tlth_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .status        (dp_status),
    .command       (command),
    .node_id       (node_id),
    .lock_slot     (lock_slot),
    .ticket        (ticket),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .issued_ticket (issued_ticket),
    .granted       (granted),
    .handoff       (handoff)
  );

endmodule

@@ tb/ticket_lock_table_hand_over_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_lock_table_hand_over_core_test: self-checking bench for the lock table
// Drives acquire / poll / release items in random bursts over several
// max_hand_over settings and checks every result against a local model
// of the ticket table kept in a small scoreboard class.
// ----------------------------------------------------------------------------
import tlth_pkg::*;

typedef struct packed {
  logic [TICKET_W-1:0] ticket;
  logic                granted;
  logic                handoff;
} lock_reply_t;

class lock_table_board;
  bit [TICKET_W-1:0] next_tk [ENTRY_COUNT];
  bit [TICKET_W-1:0] serving [ENTRY_COUNT];
  bit                flag    [ENTRY_COUNT];
  bit [COUNT_W-1:0]  streak  [ENTRY_COUNT];
  bit [MAXHO_W-1:0]  handover_limit;
  lock_reply_t       due_replies [$];
  int                grants, handoffs, saturations, checked;

  function new();
    foreach (next_tk[i]) begin
      next_tk[i] = '0;
      serving[i] = '0;
      flag[i]    = 1'b0;
      streak[i]  = '0;
    end
    handover_limit = MAXHO_RESET;
  endfunction

  function void set_limit(bit [MAXHO_W-1:0] v);
    handover_limit = v;
  endfunction

  function int outstanding();
    return due_replies.size();
  endfunction

  function bit [TICKET_W-1:0] serving_at(logic [NODE_W-1:0] node, logic [INDEX_W-1:0] idx);
    return serving[int'(node) * LOCK_COUNT + int'(idx)];
  endfunction

  // a grant bumps the streak (saturating) and reports the inherited flag
  function logic count_grant(int e);
    if (streak[e] != COUNT_MAX) streak[e]++;
    else saturations++;
    grants++;
    return flag[e];
  endfunction

  function void take_request(cmd_t cmd, logic [NODE_W-1:0] node, logic [INDEX_W-1:0] idx,
                             logic [TICKET_W-1:0] tk);
    lock_reply_t       r;
    int                e;
    bit [TICKET_W-1:0] waiting;
    bit                give;
    r = '0;
    if (int'(node) < NODE_COUNT && int'(idx) < LOCK_COUNT) begin
      e = int'(node) * LOCK_COUNT + int'(idx);
      case (cmd)
        CMD_ACQUIRE: begin
          r.ticket = next_tk[e];
          next_tk[e]++;
          if (r.ticket == serving[e]) begin
            r.granted = 1'b1;
            r.handoff = count_grant(e);
          end
        end
        CMD_POLL: begin
          r.ticket = tk;
          if (tk == serving[e]) begin
            r.granted = 1'b1;
            r.handoff = count_grant(e);
          end
        end
        CMD_RELEASE: begin
          waiting = next_tk[e] - serving[e];
          give    = (waiting > 1) && (streak[e] < COUNT_W'(handover_limit));
          if (!give) streak[e] = '0;
          flag[e] = give;
          if (waiting != 0) serving[e]++;
          r.handoff = give;
          if (give) handoffs++;
        end
        default: ;
      endcase
    end
    due_replies.push_back(r);
  endfunction

  // empty string when the result matches the oldest expectation
  function string match_reply(lock_reply_t got);
    lock_reply_t want;
    string       why;
    if (due_replies.size() == 0)
      return $sformatf("result with nothing outstanding (ticket %h)", got.ticket);
    want = due_replies.pop_front();
    checked++;
    why = "";
    if (got.ticket !== want.ticket)
      why = {why, $sformatf(" issued_ticket %h want %h", got.ticket, want.ticket)};
    if (got.granted !== want.granted)
      why = {why, $sformatf(" granted %b want %b", got.granted, want.granted)};
    if (got.handoff !== want.handoff)
      why = {why, $sformatf(" handoff %b want %b", got.handoff, want.handoff)};
    return why;
  endfunction
endclass

module ticket_lock_table_hand_over_core_test;

  // slowest run: the full clear sweep, ~1400 items with random gaps between bursts;
  // the limit sits well above all of that
  localparam int RUN_LIMIT   = 200_000;
  localparam int PHASE_ITEMS = 210;
  localparam int HOT_COUNT   = 5;
  localparam int SAT_POLLS   = 40;
  localparam int PRINT_CAP   = 40;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                start       = 1'b0;
  logic [CMD_W-1:0]    command     = CMD_NONE;
  logic [NODE_W-1:0]   node_id     = '0;
  logic [INDEX_W-1:0]  lock_slot   = '0;
  logic [TICKET_W-1:0] ticket      = '0;
  logic                cfg_wr_en   = 1'b0;
  logic [MAXHO_W-1:0]  cfg_wr_data = '0;
  logic                busy, done, granted, handoff;
  logic [TICKET_W-1:0] issued_ticket;

  lock_table_board board = new();
  int mismatches  = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int settings    = 1;

  logic [NODE_W-1:0]  hot_node  [HOT_COUNT];
  logic [INDEX_W-1:0] hot_index [HOT_COUNT];

  always #2 clk = ~clk;

  ticket_lock_table_hand_over_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .node_id       (node_id),
    .lock_slot     (lock_slot),
    .ticket        (ticket),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .issued_ticket (issued_ticket),
    .granted       (granted),
    .handoff       (handoff)
  );

  task automatic report_mismatch(input string why);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch:%s", $realtime, why);
  endtask

  // Result side: done is a one-cycle strobe and cannot be held off, so every
  // edge with done high is one result. Values read here are pre-edge values.
  always @(posedge clk) begin : result_watch
    lock_reply_t got;
    string       why;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.outstanding());
      $display("ticket_lock_table_hand_over_core_test NOT OK");
      $finish;
    end else if (!rst && done === 1'b1) begin
      got.ticket  = issued_ticket;
      got.granted = granted;
      got.handoff = handoff;
      why = board.match_reply(got);
      if (why != "") report_mismatch(why);
    end
  end

  // Presents one item and holds it until the edge where busy is low.
  // start is left high so the next item of a burst follows back to back.
  task automatic send_item(input cmd_t cmd, input logic [NODE_W-1:0] node,
                           input logic [INDEX_W-1:0] idx, input logic [TICKET_W-1:0] tk);
    start     <= 1'b1;
    command   <= cmd;
    node_id   <= node;
    lock_slot <= idx;
    ticket    <= tk;
    do @(posedge clk); while (busy !== 1'b0);
    board.take_request(cmd, node, idx, tk);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait until every expected result is in, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAXHO_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.set_limit(v);
    cfg_wr_en   <= 1'b0;
    settings++;
  endtask

  // Mostly well-formed lock traffic on a few hot entries so waiters pile up
  // and hand-overs happen; the rest lands anywhere in the table.
  task automatic random_item();
    logic [NODE_W-1:0]   node;
    logic [INDEX_W-1:0]  idx;
    logic [TICKET_W-1:0] tk;
    cmd_t                cmd;
    int                  pick, h;
    if ($urandom_range(0, 4) != 0) begin
      h    = $urandom_range(0, HOT_COUNT - 1);
      node = hot_node[h];
      idx  = hot_index[h];
    end else begin
      node = NODE_W'($urandom);
      idx  = INDEX_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 36)      cmd = CMD_ACQUIRE;
    else if (pick < 66) cmd = CMD_POLL;
    else if (pick < 95) cmd = CMD_RELEASE;
    else                cmd = CMD_NONE;
    tk   = $urandom;
    pick = $urandom_range(0, 9);
    // polls mostly hit the owner, some a waiter, a few are junk tickets
    if (cmd == CMD_POLL && pick < 6)
      tk = board.serving_at(node, idx);
    else if (cmd == CMD_POLL && pick < 8)
      tk = board.serving_at(node, idx) + $urandom_range(1, 3);
    send_item(cmd, node, idx, tk);
  endtask

  initial begin : stimulus
    logic [MAXHO_W-1:0] limits [6];
    int                 sent, burst, gap;
    limits = '{MAXHO_RESET, 8'd0, 8'hFF, 8'd1, 8'd3, 8'd0};
    limits[5] = MAXHO_W'($urandom);
    hot_node[0] = '0;  hot_index[0] = '0;
    hot_node[1] = '1;  hot_index[1] = '1;
    for (int i = 2; i < HOT_COUNT; i++) begin
      hot_node[i]  = NODE_W'($urandom);
      hot_index[i] = INDEX_W'($urandom);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // table clear sweep runs with busy high
    do @(posedge clk); while (busy !== 1'b0);

    // ---- directed, max_hand_over at its reset value ----
    send_item(CMD_RELEASE, 3'd0, 10'd0, 32'h0);          // release of an idle lock
    send_item(CMD_ACQUIRE, 3'd0, 10'd0, 32'hFFFF_FFFF);   // ticket 0, granted
    send_item(CMD_ACQUIRE, 3'd0, 10'd0, 32'h0);           // ticket 1 waits
    send_item(CMD_ACQUIRE, 3'd0, 10'd0, 32'h0);           // ticket 2 waits
    send_item(CMD_POLL,    3'd0, 10'd0, 32'd1);           // not yet
    send_item(CMD_POLL,    3'd0, 10'd0, 32'd0);           // repeated poll grants again
    send_item(CMD_RELEASE, 3'd0, 10'd0, 32'h0);           // waiters: local hand-over
    send_item(CMD_POLL,    3'd0, 10'd0, 32'd1);           // granted, flag inherited
    send_item(CMD_RELEASE, 3'd0, 10'd0, 32'h0);
    send_item(CMD_POLL,    3'd0, 10'd0, 32'd2);
    send_item(CMD_RELEASE, 3'd0, 10'd0, 32'h0);           // no waiter: global release
    send_item(CMD_RELEASE, 3'd0, 10'd0, 32'h0);           // idle again
    send_item(CMD_NONE,    3'd7, 10'd1023, 32'hFFFF_FFFF); // unused command
    send_item(CMD_ACQUIRE, 3'd7, 10'd1023, 32'h0);
    send_item(CMD_POLL,    3'd7, 10'd1023, 32'hFFFF_FFFF);
    send_item(CMD_POLL,    3'd7, 10'd1023, 32'h0);
    send_item(CMD_RELEASE, 3'd7, 10'd1023, 32'hFFFF_FFFF);
    send_item(CMD_ACQUIRE, 3'd3, 10'd512, 32'h8000_0000);
    send_item(CMD_POLL,    3'd3, 10'd512, 32'h8000_0000);
    send_item(CMD_NONE,    3'd0, 10'd0, 32'h0);

    // ---- long run of repeat grants on one entry ----
    send_item(CMD_ACQUIRE, 3'd5, 10'd777, 32'h0);
    send_item(CMD_ACQUIRE, 3'd5, 10'd777, 32'h0);
    for (int i = 0; i < SAT_POLLS; i++) send_item(CMD_POLL, 3'd5, 10'd777, 32'd0);
    send_item(CMD_RELEASE, 3'd5, 10'd777, 32'h0);          // streak past limit: no hand-over
    send_item(CMD_POLL,    3'd5, 10'd777, 32'd1);

    // ---- random phases, one per max_hand_over setting ----
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        write_limit(limits[p]);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst; b++) random_item();
        sent += burst;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        if ($urandom_range(0, 11) == 0) drain();
        else pause_sender(gap);
      end
    end

    drain();
    repeat (6) @(posedge clk);

    $display("run: %0d items, %0d results checked, %0d max_hand_over settings (0 and 255 incl.)",
             items_sent, board.checked, settings);
    $display("run: %0d grants, %0d local hand-overs, %0d grants at saturated count",
             board.grants, board.handoffs, board.saturations);
    if (mismatches == 0)
      $display("ticket_lock_table_hand_over_core_test OK");
    else
      $display("ticket_lock_table_hand_over_core_test NOT OK");
    $finish;
  end

endmodule
